### src/mpsq_pkg.sv
// Package for the multilevel priority stack queue.
// Holds the item types, status and op codes, controller states and default sizes.
// No dependencies.
package mpsq_pkg;

  localparam int LEVELS_DEF      = 4;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  level;
    logic [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] data_out;
    status_t     status;
    logic        now_empty;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

### src/mpsq_ctrl.sv
// Controller state machine for the multilevel priority stack queue.
// Depends on mpsq_pkg (state_t, ctrl_cmd_t).
module mpsq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output mpsq_pkg::ctrl_cmd_t cmd
);

  mpsq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpsq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpsq_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = mpsq_pkg::S_EXEC;
        end
      end
      mpsq_pkg::S_EXEC: state_nxt = mpsq_pkg::S_RESP;
      mpsq_pkg::S_RESP: state_nxt = mpsq_pkg::S_IDLE;
      default:          state_nxt = mpsq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      mpsq_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      mpsq_pkg::S_EXEC: cmd.exec = 1'b1;
      mpsq_pkg::S_RESP: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

### src/mpsq_datapath.sv
// Datapath for the multilevel priority stack queue: level fill counts,
// entry memory, highest-level search and result registers.
// Depends on mpsq_pkg (item types, codes, ctrl_cmd_t).
module mpsq_datapath #(
  parameter int LEVELS      = mpsq_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = mpsq_pkg::LEVEL_DEPTH_DEF,
  parameter int DATA_WIDTH  = mpsq_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mpsq_pkg::ctrl_cmd_t cmd,
  input  mpsq_pkg::in_item_t  in_item,
  output mpsq_pkg::out_item_t out_item
);

  localparam int LVL_W   = $clog2(LEVELS);
  localparam int FILL_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int IDX_W   = $clog2(LEVEL_DEPTH);
  localparam int ENTRIES = LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);

  mpsq_pkg::in_item_t   req_r;
  logic [FILL_W-1:0]    fill_r   [LEVELS];
  logic [FILL_W-1:0]    fill_nxt [LEVELS];
  logic [DATA_WIDTH-1:0] store_r [ENTRIES];
  logic [DATA_WIDTH-1:0] rd_data_r;
  mpsq_pkg::status_t    status_r;
  logic                 empty_r;
  logic                 hit_r;

  logic              lvl_ok;
  logic [LVL_W-1:0]  enq_lvl;
  logic              enq_full;
  logic              do_enq;
  logic              deq_found;
  logic [LVL_W-1:0]  deq_lvl;
  logic              do_deq;
  logic [FILL_W-1:0] deq_cnt_m1;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              any_left;

  // Enqueue target and drop check.
  assign lvl_ok   = 32'(req_r.level) < 32'(LEVELS);
  assign enq_lvl  = LVL_W'(req_r.level);
  assign enq_full = !lvl_ok || (fill_r[enq_lvl] == FILL_W'(LEVEL_DEPTH));
  assign do_enq   = cmd.exec && (req_r.op == mpsq_pkg::OP_ENQ) && !enq_full;

  // Highest non-empty level; later (higher) hits override.
  always_comb begin
    deq_found = 1'b0;
    deq_lvl   = '0;
    for (int k = 0; k < LEVELS; k++) begin
      if (fill_r[k] != '0) begin
        deq_found = 1'b1;
        deq_lvl   = LVL_W'(k);
      end
    end
  end

  assign do_deq     = cmd.exec && (req_r.op == mpsq_pkg::OP_DEQ) && deq_found;
  assign deq_cnt_m1 = fill_r[deq_lvl] - FILL_W'(1);

  assign wr_addr = ADDR_W'(enq_lvl) * ADDR_W'(LEVEL_DEPTH)
                 + ADDR_W'(fill_r[enq_lvl][IDX_W-1:0]);
  assign rd_addr = ADDR_W'(deq_lvl) * ADDR_W'(LEVEL_DEPTH)
                 + ADDR_W'(deq_cnt_m1[IDX_W-1:0]);

  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      fill_nxt[k] = fill_r[k];
    end
    if (do_enq) begin
      fill_nxt[enq_lvl] = fill_r[enq_lvl] + FILL_W'(1);
    end
    if (do_deq) begin
      fill_nxt[deq_lvl] = deq_cnt_m1;
    end
  end

  always_comb begin
    any_left = 1'b0;
    for (int k = 0; k < LEVELS; k++) begin
      any_left = any_left | (fill_nxt[k] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LEVELS; k++) begin
        fill_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < LEVELS; k++) begin
        fill_r[k] <= fill_nxt[k];
      end
    end
  end

  // Request capture and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
    if (cmd.exec) begin
      empty_r <= !any_left;
      hit_r   <= do_deq;
      if (req_r.op == mpsq_pkg::OP_ENQ) begin
        status_r <= enq_full ? mpsq_pkg::ST_FULL : mpsq_pkg::ST_OK;
      end else begin
        status_r <= deq_found ? mpsq_pkg::ST_OK : mpsq_pkg::ST_EMPTY;
      end
    end
  end

  // Entry memory: one write or one registered read per item.
  always_ff @(posedge clk) begin
    if (do_enq) begin
      store_r[wr_addr] <= DATA_WIDTH'(req_r.data_in);
    end
    if (do_deq) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign out_item.data_out  = hit_r ? 32'(rd_data_r) : 32'd0;
  assign out_item.status    = status_r;
  assign out_item.now_empty = empty_r;

endmodule

### src/multilevel_priority_stack_queue.sv
// Top level of the multilevel priority stack queue (bucket priority queue,
// last-in-first-out within a level). Instantiates mpsq_ctrl and mpsq_datapath.
// Depends on mpsq_pkg.
//
// Usage:
//   Input channel: drive in_item with start high; the item is taken at the
//   rising edge where start is high and busy is low. op OP_ENQ pushes
//   data_in onto the stack of level; OP_DEQ pops the newest entry of the
//   highest non-empty level.
//   Result channel: out_valid strobes for exactly one cycle with out_item
//   (data_out, status, now_empty). The receiver cannot stall; sample it then.
//   Every item gives exactly one result.
// Timing: an accepted item is registered in the capture step and its result
//   is strobed once the execute step is done; busy stays high until that
//   result cycle ends, so the block takes no new item before it is through
//   with the last. The three steps are capture, execute (count update plus one
//   entry memory write or registered read), and result.
// Reset: rst_n low (synchronous) empties every level and returns the
//   controller to idle; entry memory contents are not cleared and need no
//   clearing pass, since only entries below a level's fill count are read.
// Drops: an enqueue to a full level returns status full and changes nothing;
//   a dequeue from an empty queue returns zero with status empty.
module multilevel_priority_stack_queue #(
  parameter int LEVELS      = mpsq_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = mpsq_pkg::LEVEL_DEPTH_DEF,
  parameter int DATA_WIDTH  = mpsq_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mpsq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output mpsq_pkg::out_item_t out_item
);

  mpsq_pkg::ctrl_cmd_t cmd;

  // Sequence capture, execute and result strobe.
  mpsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Hold fill counts and entries; compute the result of each item.
  mpsq_datapath #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // The result strobe lasts one cycle and frees the block afterwards.
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  // A result is strobed while busy only.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // A failed item returns a zero word.
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != mpsq_pkg::ST_OK)) |-> (out_item.data_out == 32'd0))
    else $error("nonzero data on failed item");
`endif

endmodule

### sim/mpsq_checker.sv
`timescale 1ns / 1ps
// Checker for the multilevel priority stack queue: tracks the level stacks,
// predicts each result and compares it with what the block strobes out.
// Depends on mpsq_pkg.
module mpsq_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  mpsq_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  mpsq_pkg::out_item_t out_item,
  output int                  fails,
  output int                  pending
);

  localparam int NLEV  = mpsq_pkg::LEVELS_DEF;
  localparam int DEPTH = mpsq_pkg::LEVEL_DEPTH_DEF;

  logic [31:0]         stack_words [NLEV][DEPTH];
  int                  stack_fill [NLEV];
  mpsq_pkg::out_item_t awaited_results [$];

  // Apply one item to the tracked stacks and return the result it gives.
  function automatic mpsq_pkg::out_item_t serve_request(mpsq_pkg::in_item_t rq);
    mpsq_pkg::out_item_t r;
    int        k;
    int        lv;
    bit        found;
    bit        none_left;
    r         = '0;
    r.status  = mpsq_pkg::ST_OK;
    lv        = int'(rq.level);
    found     = 1'b0;
    none_left = 1'b1;
    if (rq.op == mpsq_pkg::OP_ENQ) begin
      if (lv >= NLEV || stack_fill[lv] >= DEPTH) begin
        r.status = mpsq_pkg::ST_FULL;
      end else begin
        stack_words[lv][stack_fill[lv]] = rq.data_in;
        stack_fill[lv]++;
      end
    end else begin
      for (k = NLEV - 1; k >= 0 && !found; k--) begin
        if (stack_fill[k] != 0) begin
          stack_fill[k]--;
          r.data_out = stack_words[k][stack_fill[k]];
          found      = 1'b1;
        end
      end
      if (!found) r.status = mpsq_pkg::ST_EMPTY;
    end
    for (k = 0; k < NLEV; k++) begin
      if (stack_fill[k] != 0) none_left = 1'b0;
    end
    r.now_empty = none_left;
    return r;
  endfunction

  assign pending = awaited_results.size();

  initial fails = 0;

  always @(posedge clk) begin
    mpsq_pkg::out_item_t want;
    if (!rst_n) begin
      foreach (stack_fill[i]) stack_fill[i] = 0;
      awaited_results.delete();
    end else begin
      // Compare first: a result always belongs to an item taken earlier.
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing outstanding: %p", out_item);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          if (out_item.data_out !== want.data_out) begin
            $error("data_out: expected %h, got %h", want.data_out, out_item.data_out);
            fails++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            fails++;
          end
          if (out_item.now_empty !== want.now_empty) begin
            $error("now_empty: expected %b, got %b", want.now_empty, out_item.now_empty);
            fails++;
          end
        end
      end
      if (start && !busy) awaited_results = {awaited_results, serve_request(in_item)};
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Top of the multilevel priority stack queue testbench: clock, reset, stimulus
// and verdict. Depends on mpsq_pkg, mpsq_checker and the block itself.
module tb;

  localparam int RANDOM_ITEMS = 1030;
  localparam int NLEV         = mpsq_pkg::LEVELS_DEF;
  localparam int DEPTH        = mpsq_pkg::LEVEL_DEPTH_DEF;

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  mpsq_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  mpsq_pkg::out_item_t out_item;
  int                  fails;
  int                  pending;

  // 10 ns clock: low half first, then high.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multilevel_priority_stack_queue i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  mpsq_checker i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .fails    (fails),
    .pending  (pending)
  );

  // Present one item and hold it until the block takes it. The loop exits
  // at the edge of acceptance; start stays high so a following item can be
  // driven at once without a second assignment in this step.
  task automatic offer(input mpsq_pkg::in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a random gap now and then; the gap lengths vary so that
  // the next item lands on every phase of the operation.
  task automatic maybe_pause(input bit quiet);
    if (!quiet && $urandom_range(99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic mpsq_pkg::in_item_t pick_item(input int push_pct);
    mpsq_pkg::in_item_t it;
    int       sel;
    it.op    = ($urandom_range(99) < push_pct) ? mpsq_pkg::OP_ENQ : mpsq_pkg::OP_DEQ;
    it.level = 2'($urandom_range(NLEV - 1));
    sel      = $urandom_range(9);
    // Bias part of the payloads toward the all-zero and all-one words.
    if (sel == 0)      it.data_in = 32'h0000_0000;
    else if (sel == 1) it.data_in = 32'hFFFF_FFFF;
    else               it.data_in = $urandom;
    return it;
  endfunction

  function automatic mpsq_pkg::in_item_t mk(input mpsq_pkg::op_t op, input int lv,
                                            input logic [31:0] d);
    mpsq_pkg::in_item_t it;
    it.op      = op;
    it.level   = 2'(lv);
    it.data_in = d;
    return it;
  endfunction

  initial begin
    int sent;
    int burst_left;
    int push_pct;
    int n;

    // Hold reset, then release it at an edge.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pop from an empty queue first.
    offer(mk(mpsq_pkg::OP_DEQ, 3, 32'hFFFF_FFFF));
    maybe_pause(1'b0);
    // One word per lower level, with the payload extremes.
    offer(mk(mpsq_pkg::OP_ENQ, 0, 32'h0000_0000));
    offer(mk(mpsq_pkg::OP_ENQ, 1, 32'hFFFF_FFFF));
    maybe_pause(1'b0);
    offer(mk(mpsq_pkg::OP_ENQ, 2, 32'hA5A5_5A5A));
    // Fill the top level to the brim, then push once more to see the drop.
    for (n = 0; n <= DEPTH; n++) begin
      offer(mk(mpsq_pkg::OP_ENQ, 3, (n == 0) ? 32'hFFFF_FFFF : $urandom));
      maybe_pause(1'b0);
    end
    // Pop twice: the newest words of the top level come back first.
    offer(mk(mpsq_pkg::OP_DEQ, 0, 32'h0000_0000));
    offer(mk(mpsq_pkg::OP_DEQ, 1, $urandom));

    // Random part in bursts: filling, draining or mixed, so that levels run
    // both full and empty many times. Keep one long stretch free of gaps.
    sent       = 0;
    burst_left = 0;
    push_pct   = 50;
    while (sent < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(10, 70);
        case ($urandom_range(2))
          0: begin
            push_pct = 85;
          end
          1: begin
            push_pct = 15;
          end
          default: begin
            push_pct = 50;
          end
        endcase
      end
      offer(pick_item(push_pct));
      sent++;
      burst_left--;
      maybe_pause(sent >= 300 && sent < 520);
    end
    start <= 1'b0;

    // Wait for the outstanding results, then watch for stray strobes.
    for (n = 0; n < 200 && pending != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);

    if (fails == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run well after the slowest correct one would have finished.
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
